// ===== sv/lru_set_assoc_cache_sim_unit_macros.svh =====
// ---------------------------------------------------------------------------
// LRU cache simulator assertion macros
// Short forms for the concurrent checks of the cache simulator modules.
// They assume a clock named clock and a synchronous active-high reset named reset.
// ---------------------------------------------------------------------------
`ifndef LRU_SET_ASSOC_CACHE_SIM_UNIT_MACROS_SVH
`define LRU_SET_ASSOC_CACHE_SIM_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSAC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSAC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lsac_pkg.sv =====
// ---------------------------------------------------------------------------
// LRU cache simulator package
// Field widths, register indexes, codes and the controller/datapath interface.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsac_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAYS     = 8;
   localparam int DEF_ADDR_WIDTH   = 32;

   // Stream field widths.
   localparam int CMD_W        = 2;
   localparam int ADDR_FIELD_W = 32;
   localparam int OUTCOME_W    = 2;
   localparam int TOTAL_W      = 32;
   localparam int REQ_TDATA_W  = 40;
   localparam int RSP_TDATA_W  = 104;

   // Configuration port.
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 5;
   localparam int SET_BITS_W   = 3;
   localparam int BLOCK_BITS_W = 5;
   localparam int WAYS_W       = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   localparam logic [SET_BITS_W-1:0]   RST_SET_BITS   = 3'd4;
   localparam logic [BLOCK_BITS_W-1:0] RST_BLOCK_BITS = 5'd4;
   localparam logic [WAYS_W-1:0]       RST_WAYS       = 4'd1;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_MODIFY   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   // LRU age of a line; zero is the most recently used.
   localparam int AGE_W = 3;
   localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_HIT   = 2'd0,
      OUT_MISS  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear;   // clear one set of valid bits in the pass after reset
      logic load;    // capture the accepted request
      logic rd;      // split the address and read the set
      logic eval;    // resolve the access, update the set, present a result
      logic second;  // present the second (hit) result of a modify
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_done; // the clearing pass is at its last set
      logic out_free;   // the result register can take a new result this cycle
      logic is_modify;  // the captured request is a modify
   } dp_status_type;

endpackage

`default_nettype wire

// ===== sv/lsac_ctrl.sv =====
// ---------------------------------------------------------------------------
// LRU cache simulator controller
// Sequences the valid-bit clearing pass after reset, capture, set read,
// resolve and the second result of a modify.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_set_assoc_cache_sim_unit_macros.svh"

module lsac_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [lsac_pkg::CMD_W-1:0] req_cmd,
   input  lsac_pkg::dp_status_type  status,
   output lsac_pkg::dp_cmd_type     cmd
);
   import lsac_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_EVAL   = 5'b01000,
      ST_SECOND = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            // One set of valid bits is cleared per cycle.
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // A reserved command is taken and dropped.
            if (accept && (req_cmd != CMD_RESERVED)) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (status.out_free) begin
               cmd.eval = 1'b1;
               state_in = status.is_modify ? ST_SECOND : ST_IDLE;
            end
         end
         ST_SECOND: begin
            if (status.out_free) begin
               cmd.second = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `LSAC_ASSERT_NEXT(a_accept_reads, accept && (req_cmd != CMD_RESERVED), state_ff == ST_READ, "accepted request did not start a set read")
   `LSAC_ASSERT_NOW(a_result_slot_free, cmd.eval || cmd.second, status.out_free, "result presented while the result register was busy")
   `LSAC_ASSERT_NEXT(a_single_done, (state_ff == ST_EVAL) && status.out_free && !status.is_modify, state_ff == ST_IDLE, "load or store did not finish after its result")

endmodule

`default_nettype wire

// ===== sv/lsac_dp.sv =====
// ---------------------------------------------------------------------------
// LRU cache simulator datapath
// Configuration, tag, age and valid memories, way compare, LRU update and totals.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_set_assoc_cache_sim_unit_macros.svh"

module lsac_dp #(
   parameter int MAX_SET_BITS = lsac_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = lsac_pkg::DEF_MAX_WAYS,
   parameter int ADDR_WIDTH   = lsac_pkg::DEF_ADDR_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lsac_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [lsac_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [lsac_pkg::CMD_W-1:0]           req_cmd,
   input  logic [lsac_pkg::ADDR_FIELD_W-1:0]    req_address,
   input  lsac_pkg::dp_cmd_type                 cmd,
   output lsac_pkg::dp_status_type              status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lsac_pkg::OUTCOME_W-1:0]       rsp_outcome,
   output logic                                 rsp_last,
   output logic [lsac_pkg::TOTAL_W-1:0]         hit_total,
   output logic [lsac_pkg::TOTAL_W-1:0]         miss_total,
   output logic [lsac_pkg::TOTAL_W-1:0]         evict_total
);
   import lsac_pkg::*;

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int SHIFT_W  = 6;
   localparam int WCMP_W   = 6;
   localparam logic [SHIFT_W-1:0] MAX_S   = SHIFT_W'(MAX_SET_BITS);
   localparam logic [SHIFT_W-1:0] AW_SH   = SHIFT_W'(ADDR_WIDTH);
   localparam logic [IDX_W-1:0]   LAST_SET = IDX_W'(NUM_SETS - 1);

   typedef logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row_type;
   typedef logic [MAX_WAYS-1:0][AGE_W-1:0]      age_row_type;

   // Configuration registers.
   logic [SET_BITS_W-1:0]   set_bits_ff;
   logic [BLOCK_BITS_W-1:0] block_bits_ff;
   logic [WAYS_W-1:0]       ways_ff;

   // Captured request and the split address.
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic                  modify_ff;
   logic [ADDR_WIDTH-1:0] tag_ff, tag_in;
   logic [IDX_W-1:0]      set_idx_ff, set_idx_in;

   // Set storage: tags, ages and valid bits are memories. The valid bits are
   // cleared one set per cycle by the pass that follows reset.
   tag_row_type         tag_mem [NUM_SETS];
   age_row_type         age_mem [NUM_SETS];
   logic [MAX_WAYS-1:0] valid_mem [NUM_SETS];
   logic [IDX_W-1:0]    clear_idx_ff;

   tag_row_type         tag_row_ff, tag_row_in;
   age_row_type         age_row_ff, age_row_in;
   logic [MAX_WAYS-1:0] valid_row_ff, valid_row_in;

   // Way resolution.
   logic [MAX_WAYS-1:0] in_use, hit_vec, empty_vec;
   logic                hit_any, empty_any, old_all;
   logic [WAY_W-1:0]    hit_way, empty_way, victim_way, way_sel;
   logic [AGE_W-1:0]    victim_age, old_age;
   outcome_type         outcome;

   // Totals and result register.
   logic [TOTAL_W-1:0]   hit_cnt_ff, miss_cnt_ff, evict_cnt_ff;
   logic                 rsp_valid_ff;
   logic [OUTCOME_W-1:0] outcome_ff;
   logic                 last_ff;

   logic [SHIFT_W-1:0] s_eff, sb_sum, b_ext;
   logic [IDX_W-1:0]   idx_mask;

   // Address split: offset below block_bits, set index above it, tag on top.
   always_comb begin
      b_ext    = SHIFT_W'(block_bits_ff);
      s_eff    = (SHIFT_W'(set_bits_ff) > MAX_S) ? MAX_S : SHIFT_W'(set_bits_ff);
      sb_sum   = s_eff + b_ext;
      idx_mask = ~({IDX_W{1'b1}} << s_eff);
      tag_in   = (sb_sum >= AW_SH) ? '0 : (addr_ff >> sb_sum);
      set_idx_in = (b_ext >= AW_SH) ? '0 : (IDX_W'(addr_ff >> b_ext) & idx_mask);
   end

   // Compare, empty search and LRU victim search over the ways in use.
   always_comb begin
      hit_way    = '0;
      empty_way  = '0;
      victim_way = '0;
      victim_age = age_row_ff[0];
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w]    = (w == 0) || ({2'b00, ways_ff} > WCMP_W'(w));
         hit_vec[w]   = in_use[w] && valid_row_ff[w] && (tag_row_ff[w] == tag_ff);
         empty_vec[w] = in_use[w] && !valid_row_ff[w];
      end
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (empty_vec[w]) begin
            empty_way = WAY_W'(w);
         end
      end
      // Oldest valid way; strict compare keeps the lowest way on a tie.
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (in_use[w] && valid_row_ff[w] && (age_row_ff[w] > victim_age)) begin
            victim_way = WAY_W'(w);
            victim_age = age_row_ff[w];
         end
      end
      hit_any   = |hit_vec;
      empty_any = |empty_vec;

      priority if (hit_any) begin
         way_sel = hit_way;
         old_age = age_row_ff[hit_way];
         old_all = 1'b0;
         outcome = OUT_HIT;
      end else if (empty_any) begin
         way_sel = empty_way;
         old_age = '0;
         old_all = 1'b1;
         outcome = OUT_MISS;
      end else begin
         way_sel = victim_way;
         old_age = victim_age;
         old_all = 1'b0;
         outcome = OUT_EVICT;
      end

      // Every valid way younger than the touched one ages by one, up to the cap.
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (WAY_W'(w) == way_sel) begin
            age_row_in[w] = '0;
         end else if (in_use[w] && valid_row_ff[w] && (old_all || (age_row_ff[w] < old_age))
                      && (age_row_ff[w] != AGE_MAX)) begin
            age_row_in[w] = age_row_ff[w] + AGE_W'(1);
         end else begin
            age_row_in[w] = age_row_ff[w];
         end
      end

      tag_row_in          = tag_row_ff;
      tag_row_in[way_sel] = tag_ff;
      valid_row_in          = valid_row_ff;
      valid_row_in[way_sel] = 1'b1;
   end

   // Memories: read in the set-read cycle, written when the access resolves
   // or, for the valid bits, by the clearing pass.
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         tag_row_ff   <= tag_mem[set_idx_in];
         age_row_ff   <= age_mem[set_idx_in];
         valid_row_ff <= valid_mem[set_idx_in];
      end
      if (cmd.clear) begin
         valid_mem[clear_idx_ff] <= '0;
      end else if (cmd.eval) begin
         age_mem[set_idx_ff] <= age_row_in;
         if (!hit_any) begin
            tag_mem[set_idx_ff]   <= tag_row_in;
            valid_mem[set_idx_ff] <= valid_row_in;
         end
      end
   end

   // Request capture and split address; payload only.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff   <= req_address[ADDR_WIDTH-1:0];
         modify_ff <= (req_cmd == CMD_MODIFY);
      end
      if (cmd.rd) begin
         tag_ff     <= tag_in;
         set_idx_ff <= set_idx_in;
      end
      if (cmd.eval || cmd.second) begin
         outcome_ff <= cmd.eval ? outcome : OUT_HIT;
         last_ff    <= cmd.second || !modify_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= RST_SET_BITS;
         block_bits_ff <= RST_BLOCK_BITS;
         ways_ff       <= RST_WAYS;
         clear_idx_ff  <= '0;
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         evict_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_SET_BITS:   set_bits_ff   <= csr_wdata[SET_BITS_W-1:0];
               CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[BLOCK_BITS_W-1:0];
               CSR_WAYS:       ways_ff       <= csr_wdata[WAYS_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clear) begin
            clear_idx_ff <= clear_idx_ff + IDX_W'(1);
         end
         if (cmd.eval) begin
            if (hit_any) begin
               hit_cnt_ff <= (&hit_cnt_ff) ? hit_cnt_ff : hit_cnt_ff + TOTAL_W'(1);
            end else begin
               miss_cnt_ff <= (&miss_cnt_ff) ? miss_cnt_ff : miss_cnt_ff + TOTAL_W'(1);
               if (!empty_any) begin
                  evict_cnt_ff <= (&evict_cnt_ff) ? evict_cnt_ff
                                                  : evict_cnt_ff + TOTAL_W'(1);
               end
            end
         end
         if (cmd.second) begin
            hit_cnt_ff <= (&hit_cnt_ff) ? hit_cnt_ff : hit_cnt_ff + TOTAL_W'(1);
         end
         if (cmd.eval || cmd.second) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Totals only move when a result is loaded, so they are read straight out.
   assign status.clear_done = (clear_idx_ff == LAST_SET);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;
   assign status.is_modify  = modify_ff;
   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_outcome       = outcome_ff;
   assign rsp_last          = last_ff;
   assign hit_total         = hit_cnt_ff;
   assign miss_total        = miss_cnt_ff;
   assign evict_total       = evict_cnt_ff;

   `LSAC_ASSERT_NEXT(a_line_valid_after, cmd.eval, valid_mem[$past(set_idx_ff)][$past(way_sel)], "accessed line is not valid after the access")
   `LSAC_ASSERT_NEXT(a_access_counted, cmd.eval, (hit_cnt_ff != $past(hit_cnt_ff)) || (miss_cnt_ff != $past(miss_cnt_ff)) || (&$past(hit_cnt_ff)) || (&$past(miss_cnt_ff)), "access left both hit and miss totals unchanged")
   `LSAC_ASSERT_NOW(a_evict_is_miss, !$past(reset) && (evict_cnt_ff != $past(evict_cnt_ff)), (miss_cnt_ff != $past(miss_cnt_ff)) || (&$past(miss_cnt_ff)), "eviction counted without a miss")

endmodule

`default_nettype wire

// ===== sv/lru_set_assoc_cache_sim_unit.sv =====
// ---------------------------------------------------------------------------
// LRU set-associative cache simulator
// Tag store with true LRU replacement that reports hit, miss or eviction
// for every access together with saturating running totals.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  req_*     in         req_tvalid / req_tready   cmd, address
//  rsp_*     out        rsp_tvalid / rsp_tready   outcome, totals; tlast = last
//  csr_*     in         csr_we (no wait)          register index, write data
//
// A load or store runs through capture, set read from the tag, age and
// valid memories, then compare, LRU update and result. A modify adds a
// second result, which is always a hit. The single-ported set
// memories are read once and written once per access, and the controller
// handles one request at a time. A request is accepted only while the
// controller is idle; the result register frees it from a stalled result
// consumer, and a result holds until it is transferred. Reset is synchronous
// and restores the configuration and the totals. After reset a clearing pass
// zeroes the valid-bit memory one set per cycle (64 sets with six set bits),
// and no request is accepted until it is done. A request with the reserved
// command code is transferred and dropped without a result.
//
`timescale 1ns / 1ps
`default_nettype none

module lru_set_assoc_cache_sim_unit #(
   parameter int MAX_SET_BITS = lsac_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = lsac_pkg::DEF_MAX_WAYS,
   parameter int ADDR_WIDTH   = lsac_pkg::DEF_ADDR_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lsac_pkg::REQ_TDATA_W-1:0]    req_tdata,   // cmd[1:0], address[33:2], zero pad
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lsac_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // outcome[1:0], hit_total[33:2],
                                                            // miss_total[65:34],
                                                            // evict_total[97:66], zero pad
   output logic                                rsp_tlast,   // last result of the request
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [lsac_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  logic [lsac_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lsac_pkg::*;

   dp_cmd_type            cmd;
   dp_status_type         status;
   logic [CMD_W-1:0]      req_cmd;
   logic [ADDR_FIELD_W-1:0] req_address;
   logic [OUTCOME_W-1:0]  rsp_outcome;
   logic [TOTAL_W-1:0]    hit_total, miss_total, evict_total;

   // Request fields, lowest field first.
   assign req_cmd     = req_tdata[CMD_W-1:0];
   assign req_address = req_tdata[CMD_W+ADDR_FIELD_W-1:CMD_W];

   lsac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_cmd),
      .status     (status),
      .cmd        (cmd)
   );

   lsac_dp #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_cmd     (req_cmd),
      .req_address (req_address),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_outcome (rsp_outcome),
      .rsp_last    (rsp_tlast),
      .hit_total   (hit_total),
      .miss_total  (miss_total),
      .evict_total (evict_total)
   );

   // Result fields, lowest field first, padded to whole bytes.
   assign rsp_tdata = {
      {(RSP_TDATA_W - OUTCOME_W - 3 * TOTAL_W){1'b0}},
      evict_total,
      miss_total,
      hit_total,
      rsp_outcome
   };

endmodule

`default_nettype wire

// ===== tb/sv/tb_lru_set_assoc_cache_sim_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the LRU set-associative cache simulator
// Drives load, store and modify requests through several cache geometries
// and compares every result transfer with a cycle-free model of the tag store.
// ---------------------------------------------------------------------------

import lsac_pkg::*;

// One expected result: the outcome of one access and the totals after it.
typedef struct {
   outcome_type outcome;
   bit          last;
   bit [TOTAL_W-1:0] hits;
   bit [TOTAL_W-1:0] misses;
   bit [TOTAL_W-1:0] evictions;
} access_report_type;

// Tag store model plus the queue of results it still owes the checker.
class lru_tag_model;
   bit [SET_BITS_W-1:0]   set_bits_r;
   bit [BLOCK_BITS_W-1:0] block_bits_r;
   bit [WAYS_W-1:0]       ways_r;

   bit [ADDR_FIELD_W-1:0] tags  [(1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS];
   bit                    valid [(1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS];
   bit [AGE_W-1:0]        ages  [(1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS];

   bit [TOTAL_W-1:0] hits;
   bit [TOTAL_W-1:0] misses;
   bit [TOTAL_W-1:0] evictions;

   access_report_type pending[$];
   int failures;

   function new();
      set_bits_r   = RST_SET_BITS;
      block_bits_r = RST_BLOCK_BITS;
      ways_r       = RST_WAYS;
   endfunction

   function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_SET_BITS:   set_bits_r   = value[SET_BITS_W-1:0];
         CSR_BLOCK_BITS: block_bits_r = value[BLOCK_BITS_W-1:0];
         CSR_WAYS:       ways_r       = value[WAYS_W-1:0];
         default: ;
      endcase
   endfunction

   function int outstanding();
      return pending.size();
   endfunction

   function bit [TOTAL_W-1:0] bump(bit [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Make one way most recent. Valid ways in use that were younger than its
   // old age grow one step older, up to the ceiling.
   function void promote(int base, int nways, int mru, int old_age);
      int i;
      for (int w = 0; w < nways; w++) begin
         i = base + w;
         if (w != mru && valid[i] && ages[i] < old_age && ages[i] < AGE_MAX)
            ages[i] = ages[i] + 1'b1;
      end
      ages[base + mru] = '0;
   endfunction

   function outcome_type lookup(bit [ADDR_FIELD_W-1:0] addr);
      int s;
      int b;
      int nways;
      int base;
      int empty;
      int victim;
      int vage;
      bit [63:0] a;
      bit [ADDR_FIELD_W-1:0] tag;
      bit [ADDR_FIELD_W-1:0] idx;
      s     = (set_bits_r > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(set_bits_r);
      b     = int'(block_bits_r);
      nways = (ways_r == 0) ? 1 : ((ways_r > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(ways_r));
      a     = {32'd0, addr};
      tag   = ((s + b) >= DEF_ADDR_WIDTH) ? '0 : ADDR_FIELD_W'(a >> (s + b));
      idx   = (b >= DEF_ADDR_WIDTH) ? '0 : ADDR_FIELD_W'((a >> b) & ((64'd1 << s) - 1));
      base  = int'(idx & ((1 << DEF_MAX_SET_BITS) - 1)) * DEF_MAX_WAYS;

      for (int w = 0; w < nways; w++) begin
         if (valid[base + w] && tags[base + w] == tag) begin
            promote(base, nways, w, ages[base + w]);
            hits = bump(hits);
            return OUT_HIT;
         end
      end

      misses = bump(misses);
      empty  = nways;
      victim = 0;
      vage   = 0;
      for (int w = 0; w < nways; w++) begin
         if (!valid[base + w]) begin
            if (empty == nways)
               empty = w;
         end else if (w == 0 || ages[base + w] > vage) begin
            victim = w;
            vage   = ages[base + w];
         end
      end

      if (empty < nways) begin
         valid[base + empty] = 1'b1;
         tags[base + empty]  = tag;
         promote(base, nways, empty, AGE_MAX + 1);
         return OUT_MISS;
      end

      evictions = bump(evictions);
      tags[base + victim] = tag;
      promote(base, nways, victim, vage);
      return OUT_EVICT;
   endfunction

   function void record(outcome_type outcome, bit last);
      access_report_type r;
      r.outcome   = outcome;
      r.last      = last;
      r.hits      = hits;
      r.misses    = misses;
      r.evictions = evictions;
      pending.push_back(r);
   endfunction

   // Called for every accepted request transfer.
   function void note_request(bit [CMD_W-1:0] cmd, bit [ADDR_FIELD_W-1:0] addr);
      if (cmd == CMD_RESERVED)
         return;
      record(lookup(addr), cmd != CMD_MODIFY);
      if (cmd == CMD_MODIFY)
         record(lookup(addr), 1'b1);
   endfunction

   function void compare(string field, bit [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         failures++;
      end
   endfunction

   // Called for every accepted result transfer.
   function void check_result(logic [RSP_TDATA_W-1:0] data, logic tlast);
      access_report_type want;
      if (pending.size() == 0) begin
         $display("%0t: result with nothing expected, expected none, actual outcome %0d",
                  $time, data[OUTCOME_W-1:0]);
         failures++;
         return;
      end
      want = pending.pop_front();
      compare("outcome", TOTAL_W'(want.outcome), TOTAL_W'(data[OUTCOME_W-1:0]));
      compare("last", TOTAL_W'(want.last), TOTAL_W'(tlast));
      compare("hit_total", want.hits, data[OUTCOME_W +: TOTAL_W]);
      compare("miss_total", want.misses, data[OUTCOME_W + TOTAL_W +: TOTAL_W]);
      compare("evict_total", want.evictions, data[OUTCOME_W + 2 * TOTAL_W +: TOTAL_W]);
   endfunction
endclass

module tb_lru_set_assoc_cache_sim_unit;

   // Load and store differ only in name for a tag store; both are one access.
   localparam logic [CMD_W-1:0]     CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0]     CMD_STORE  = 2'd1;
   // The port can address a fourth register that does not exist.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // SETTLE_CYCLES is a safe margin after the last result before the
   // configuration changes or the run ends.
   localparam int SETTLE_CYCLES = 10;
   // No correct run goes this long without a single transfer.
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Percentage of cycles in which each side holds back; zero during the
   // back-to-back stretch in the middle of the run.
   int idle_pct = 21;
   int stall_cycles = 0;

   lru_tag_model board = new();

   lru_set_assoc_cache_sim_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // The consumer stalls at random. Every result transfer is checked at the
   // edge where it happens, and the watchdog ends a run that has stopped moving.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tlast);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offers one request after a random gap and returns at the edge where it
   // transfers. The valid stays high into the next call, so back-to-back
   // requests need no extra cycle.
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [ADDR_FIELD_W-1:0] addr);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - ADDR_FIELD_W - CMD_W){1'b0}}, addr, cmd};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_request(cmd, addr);
   endtask

   // Holds the sender until every expected result has come back, then lets
   // the block finish any request that produces no result.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all registers back to back while the block is idle. The upper
   // write-data bits beyond the set-bits and ways registers are random and must
   // be ignored, as must the write to the unused index.
   task automatic set_config(int set_v, int block_v, int ways_v);
      logic [CSR_DATA_W-1:0] values [4];
      logic [CSR_IDX_W-1:0]  idxs   [4];
      idxs[0]   = CSR_SET_BITS;
      values[0] = CSR_DATA_W'({CSR_DATA_W'($urandom), SET_BITS_W'(set_v)});
      idxs[1]   = CSR_BLOCK_BITS;
      values[1] = CSR_DATA_W'(block_v);
      idxs[2]   = CSR_WAYS;
      values[2] = CSR_DATA_W'({CSR_DATA_W'($urandom), WAYS_W'(ways_v)});
      idxs[3]   = CSR_UNUSED;
      values[3] = CSR_DATA_W'($urandom);
      for (int k = 0; k < 4; k++) begin
         csr_we    <= 1'b1;
         csr_addr  <= idxs[k];
         csr_wdata <= values[k];
         @(posedge clock);
         board.write_register(idxs[k], values[k]);
      end
      csr_we <= 1'b0;
   endtask

   // One random phase. Most addresses come from a small pool of lines spread
   // over at most two sets, more lines than ways, so that hits, fills and evictions
   // all happen often; the offset bits are scrambled since they must not
   // matter. The rest are fully random addresses.
   task automatic run_phase(int set_v, int block_v, int ways_v, int items);
      int s;
      int nways;
      int done;
      int pick;
      logic [ADDR_FIELD_W-1:0] hot_lines [$];
      logic [ADDR_FIELD_W-1:0] offset_mask;
      logic [ADDR_FIELD_W-1:0] addr;
      logic [CMD_W-1:0]        cmd;
      wait_quiet();
      set_config(set_v, block_v, ways_v);
      s           = (set_v > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : set_v;
      nways       = (ways_v == 0) ? 1 : ((ways_v > DEF_MAX_WAYS) ? DEF_MAX_WAYS : ways_v);
      offset_mask = ADDR_FIELD_W'((64'd1 << block_v) - 1);
      for (int k = 0; k < 2 * nways + 2; k++)
         hot_lines.push_back(ADDR_FIELD_W'(({32'd0, $urandom} << (s + block_v))
                                           | (64'($urandom_range(0, 1)) << block_v)));
      done = 0;
      while (done < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 5)
            cmd = CMD_RESERVED;
         else if (pick < 35)
            cmd = CMD_LOAD;
         else if (pick < 65)
            cmd = CMD_STORE;
         else
            cmd = CMD_MODIFY;
         if ($urandom_range(0, 99) < 15)
            addr = $urandom;
         else
            addr = hot_lines[$urandom_range(0, hot_lines.size() - 1)]
                   | ($urandom & offset_mask);
         send_request(cmd, addr);
         if (cmd != CMD_RESERVED)
            done++;
      end
   endtask

   initial begin
      int set_v;
      int block_v;
      int ways_v;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset geometry: 16 sets of 16-byte
      // blocks, one way. Covers both address extremes, every command, a
      // reserved command that must vanish, and a modify whose first access
      // evicts.
      send_request(CMD_LOAD,     32'h0000_0000);
      send_request(CMD_STORE,    32'h0000_000F);
      send_request(CMD_MODIFY,   32'h0000_0100);
      send_request(CMD_LOAD,     32'hFFFF_FFFF);
      send_request(CMD_STORE,    32'hFFFF_FFF0);
      send_request(CMD_RESERVED, 32'hFFFF_FFFF);
      send_request(CMD_RESERVED, 32'h0000_0000);
      send_request(CMD_LOAD,     32'h0000_0000);

      // Four ways with the old contents kept: fill set zero, then check that
      // the least recently used line is the one that goes.
      wait_quiet();
      set_config(4, 4, 4);
      send_request(CMD_LOAD,   32'h0000_0200);
      send_request(CMD_LOAD,   32'h0000_0300);
      send_request(CMD_LOAD,   32'h0000_0400);
      send_request(CMD_STORE,  32'h0000_0008);
      send_request(CMD_MODIFY, 32'h0000_0500);
      send_request(CMD_LOAD,   32'h0000_0200);
      send_request(CMD_STORE,  32'h0000_0400);
      send_request(CMD_LOAD,   32'h0000_0300);

      // Shrink to one way: lines in the upper ways are left alone and must not
      // be found. Then grow past the maximum so that they are found again.
      wait_quiet();
      set_config(4, 4, 1);
      send_request(CMD_LOAD,   32'h0000_0400);
      send_request(CMD_MODIFY, 32'h0000_0600);
      wait_quiet();
      set_config(4, 4, 15);
      send_request(CMD_LOAD,   32'h0000_0400);
      send_request(CMD_LOAD,   32'h0000_0500);

      // Random phases. The first few pin the geometry to its extremes: no set
      // bits, set bits past the maximum, offsets so wide that the tag is zero,
      // and zero ways. The middle phases run with no idling on either side.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin set_v = 0; block_v = 0;  ways_v = 1;  end
            1: begin set_v = 7; block_v = 31; ways_v = 15; end
            2: begin set_v = 6; block_v = 26; ways_v = 8;  end
            3: begin set_v = 2; block_v = 3;  ways_v = 0;  end
            4: begin set_v = 0; block_v = 31; ways_v = 2;  end
            default: begin
               set_v   = $urandom_range(0, 7);
               block_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(0, 8);
               ways_v  = $urandom_range(0, 15);
            end
         endcase
         idle_pct = (p >= 5 && p <= 7) ? 0 : 21;
         run_phase(set_v, block_v, ways_v, PHASE_ITEMS);
      end

      wait_quiet();
      if (board.failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
